// ===== hdl/pitch_from_offset_atan2_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pitch-from-offset unit
// Shared property shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PITCH_FROM_OFFSET_ATAN2_UNIT_DEFINES_SVH
`define PITCH_FROM_OFFSET_ATAN2_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFOA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfoa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfoa_pkg
// Types and constants shared by the pitch-from-offset CORDIC pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfoa_pkg;

  localparam int TABLE_LEN   = 24;
  localparam int PRESHIFT    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int OFFSET_W    = 16;
  localparam int HEIGHT_W    = 15;
  localparam int PITCH_W     = 15;
  localparam int XW          = 35;
  localparam int ZW          = 32;
  localparam int YMW         = 28;
  localparam int RAD_W       = 29;
  localparam int PW          = YMW + RAD_W;
  localparam int QB          = 24;
  localparam int DW          = PW - QB;
  localparam int RND_W       = ZW - FRAC_BITS;

  localparam logic [RAD_W-1:0] RAD_TO_UNITS = 29'd375493621;
  localparam logic [PITCH_W-1:0] PITCH_LIMIT = 15'd9000;

  localparam logic [28:0] ATAN_UNITS [TABLE_LEN] = '{
    29'd294912000, 29'd174096719, 29'd91987925, 29'd46694507,
    29'd23437865,  29'd11730358,  29'd5866610,  29'd2933484,
    29'd1466764,   29'd733385,    29'd366693,   29'd183346,
    29'd91673,     29'd45837,     29'd22918,    29'd11459,
    29'd5730,      29'd2865,      29'd1432,     29'd716,
    29'd358,       29'd179,       29'd90,       29'd45
  };

  typedef struct packed {
    logic last;
    logic h_zero;
    logic off_pos;
    logic off_neg;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cordic_t;

  typedef struct packed {
    logic [DW-1:0]        rem;
    logic [QB-1:0]        num;
    logic [QB-1:0]        q;
    logic [DW-1:0]        d;
    logic                 neg;
    logic signed [ZW-1:0] z;
    side_t                side;
  } div_t;

  typedef struct packed {
    logic                      last;
    logic signed [PITCH_W-1:0] pitch;
  } res_t;

endpackage

// ===== hdl/pitch_from_offset_atan2_unit.sv =====
// ----------------------------------------------------------------------------
// pitch_from_offset_atan2_unit
// Pitch angle atan2(offset, height) in hundredths of a degree, pipelined.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel carries one signed lateral offset and a
// last-entry flag; each transfer on the out_ channel carries one pitch angle,
// rounded to the nearest hundredth of a degree and limited to +/-9000, with
// the flag copied. The cfg_ channel writes the arm height, which is sampled
// as each item enters, so the user must write it only while the pipeline is
// empty; the block does not enforce this. The pipeline holds one CORDIC cell
// per micro-rotation, a multiplier stage, 24 restoring-division cells for
// the residual correction and three rounding and output stages. Throughput
// is one item per cycle unless the receiver stalls. While rst_n is low the
// pipeline is flushed, the height returns to 100 and neither in_ nor cfg_ is
// ready. On a receiver stall the two-entry output stage takes one more result
// into its skid entry, then in_tready drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pitch_from_offset_atan2_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] lateral_offset
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] pitch_centideg, [15] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  localparam int STEPS = (CORDIC_STEPS > pfoa_pkg::TABLE_LEN) ?
                         pfoa_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int XW = pfoa_pkg::XW;
  localparam int ZW = pfoa_pkg::ZW;
  localparam int QB = pfoa_pkg::QB;
  localparam int PW = pfoa_pkg::PW;
  localparam int YMW = pfoa_pkg::YMW;

  logic [pfoa_pkg::HEIGHT_W-1:0] height_r;
  logic                          en;

  logic [STEPS:0]    cor_valid;
  pfoa_pkg::cordic_t cor_data [STEPS+1];

  logic              mul_valid_r;
  pfoa_pkg::div_t    mul_data_r;
  pfoa_pkg::div_t    mul_data_nxt;
  logic signed [YMW-1:0] y_res;
  logic [YMW-1:0]        y_mag;
  logic [PW-1:0]         product;

  logic [QB:0]       dv_valid;
  pfoa_pkg::div_t    dv_data [QB+1];

  logic                  f1_valid_r;
  logic signed [ZW-1:0]  zt_r;
  logic signed [ZW-1:0]  zt_nxt;
  logic signed [ZW-1:0]  corr;
  pfoa_pkg::side_t       f1_side_r;

  logic                        f2_valid_r;
  logic [pfoa_pkg::RND_W-1:0]  rnd_r;
  logic [pfoa_pkg::RND_W-1:0]  rnd_nxt;
  logic                        f2_neg_r;
  pfoa_pkg::side_t             f2_side_r;
  logic [ZW-1:0]               z_mag;
  logic [ZW-1:0]               z_biased;

  logic [pfoa_pkg::PITCH_W-1:0] clamped;
  pfoa_pkg::res_t               res;
  logic                         push;
  logic                         pop;

  pfoa_pkg::res_t out_data_r;
  pfoa_pkg::res_t out_data_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  pfoa_pkg::res_t skid_data_r;
  pfoa_pkg::res_t skid_data_nxt;
  logic           skid_valid_r;
  logic           skid_valid_nxt;

  assign en        = ~skid_valid_r;
  assign in_tready = rst_n & ~skid_valid_r;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 15'd100;
    end else if (cfg_valid && cfg_ready) begin
      height_r <= cfg_data;
    end
  end

  // CORDIC chain
  assign cor_valid[0]          = in_tvalid & in_tready;
  assign cor_data[0].x         = {{(XW-pfoa_pkg::HEIGHT_W-pfoa_pkg::PRESHIFT){1'b0}},
                                  height_r, {pfoa_pkg::PRESHIFT{1'b0}}};
  assign cor_data[0].y         = {{(XW-pfoa_pkg::OFFSET_W-pfoa_pkg::PRESHIFT){in_tdata[15]}},
                                  in_tdata, {pfoa_pkg::PRESHIFT{1'b0}}};
  assign cor_data[0].z         = '0;
  assign cor_data[0].side.last    = in_tlast;
  assign cor_data[0].side.h_zero  = (height_r == '0);
  assign cor_data[0].side.off_pos = ~in_tdata[15] & (in_tdata != '0);
  assign cor_data[0].side.off_neg = in_tdata[15];

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    pfoa_cordic_cell #(
      .STAGE(5'(i))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (cor_valid[i]),
      .in_data  (cor_data[i]),
      .out_valid(cor_valid[i+1]),
      .out_data (cor_data[i+1])
    );
  end

  // Residual y times the radian-to-unit scale, sign kept apart.
  assign y_res   = cor_data[STEPS].y[YMW-1:0];
  assign y_mag   = y_res[YMW-1] ? YMW'(-y_res) : YMW'(y_res);
  assign product = PW'(y_mag) * PW'(pfoa_pkg::RAD_TO_UNITS);

  always_comb begin
    mul_data_nxt      = '0;
    mul_data_nxt.rem  = product[PW-1:QB];
    mul_data_nxt.num  = product[QB-1:0];
    mul_data_nxt.q    = '0;
    mul_data_nxt.d    = cor_data[STEPS].x[pfoa_pkg::DW-1:0];
    mul_data_nxt.neg  = cor_data[STEPS].y[XW-1];
    mul_data_nxt.z    = cor_data[STEPS].z;
    mul_data_nxt.side = cor_data[STEPS].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= cor_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_data_r <= mul_data_nxt;
    end
  end

  // Division chain
  assign dv_valid[0] = mul_valid_r;
  assign dv_data[0]  = mul_data_r;

  for (genvar k = 0; k < QB; k++) begin : g_div
    pfoa_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dv_valid[k]),
      .in_data  (dv_data[k]),
      .out_valid(dv_valid[k+1]),
      .out_data (dv_data[k+1])
    );
  end

  // Add the correction, then round the magnitude.
  assign corr   = ZW'(dv_data[QB].q);
  assign zt_nxt = dv_data[QB].neg ? (dv_data[QB].z - corr) : (dv_data[QB].z + corr);

  assign z_mag    = zt_r[ZW-1] ? ZW'(-zt_r) : ZW'(zt_r);
  assign z_biased = z_mag + ZW'(1 << (pfoa_pkg::FRAC_BITS - 1));
  assign rnd_nxt  = z_biased[ZW-1:pfoa_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= dv_valid[QB];
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zt_r      <= zt_nxt;
      f1_side_r <= dv_data[QB].side;
      rnd_r     <= rnd_nxt;
      f2_neg_r  <= zt_r[ZW-1];
      f2_side_r <= f1_side_r;
    end
  end

  // Clamp, restore the sign and handle a zero height.
  assign clamped = (rnd_r > pfoa_pkg::RND_W'(pfoa_pkg::PITCH_LIMIT)) ?
                   pfoa_pkg::PITCH_LIMIT : rnd_r[pfoa_pkg::PITCH_W-1:0];

  always_comb begin
    res.last = f2_side_r.last;
    if (f2_side_r.h_zero) begin
      priority if (f2_side_r.off_pos) begin
        res.pitch = pfoa_pkg::PITCH_LIMIT;
      end else if (f2_side_r.off_neg) begin
        res.pitch = -pfoa_pkg::PITCH_LIMIT;
      end else begin
        res.pitch = '0;
      end
    end else begin
      res.pitch = f2_neg_r ? -clamped : clamped;
    end
  end

  // Two-entry output stage
  assign push = en & f2_valid_r;
  assign pop  = out_valid_r & out_tready;

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    priority if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt = push;
      out_data_nxt  = res;
    end else if (push) begin
      skid_data_nxt  = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r.pitch};
  assign out_tlast  = out_data_r.last;

endmodule

// ===== hdl/pfoa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// pfoa_cordic_cell
// One vectoring micro-rotation of the CORDIC chain, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfoa_cordic_cell #(
  parameter logic [4:0] STAGE = 5'd0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  pfoa_pkg::cordic_t in_data,
  output logic              out_valid,
  output pfoa_pkg::cordic_t out_data
);

  pfoa_pkg::cordic_t data_nxt;
  pfoa_pkg::cordic_t data_r;
  logic              valid_r;
  logic [pfoa_pkg::ZW-1:0] angle;

  assign angle = pfoa_pkg::ZW'(pfoa_pkg::ATAN_UNITS[STAGE]);

  always_comb begin
    data_nxt = in_data;
    if (!in_data.y[pfoa_pkg::XW-1]) begin
      data_nxt.x = in_data.x + (in_data.y >>> STAGE);
      data_nxt.y = in_data.y - (in_data.x >>> STAGE);
      data_nxt.z = in_data.z + angle;
    end else begin
      data_nxt.x = in_data.x - (in_data.y >>> STAGE);
      data_nxt.y = in_data.y + (in_data.x >>> STAGE);
      data_nxt.z = in_data.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/pfoa_div_cell.sv =====
// ----------------------------------------------------------------------------
// pfoa_div_cell
// One restoring-division step: develops one quotient bit, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfoa_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pfoa_pkg::div_t in_data,
  output logic           out_valid,
  output pfoa_pkg::div_t out_data
);

  pfoa_pkg::div_t data_nxt;
  pfoa_pkg::div_t data_r;
  logic           valid_r;
  logic [pfoa_pkg::DW:0] trial;
  logic [pfoa_pkg::DW:0] divisor;
  logic [pfoa_pkg::DW:0] diff;

  assign trial   = {in_data.rem, in_data.num[pfoa_pkg::QB-1]};
  assign divisor = {1'b0, in_data.d};
  assign diff    = trial - divisor;

  always_comb begin
    data_nxt     = in_data;
    data_nxt.num = {in_data.num[pfoa_pkg::QB-2:0], 1'b0};
    if (trial >= divisor) begin
      data_nxt.rem = diff[pfoa_pkg::DW-1:0];
      data_nxt.q   = {in_data.q[pfoa_pkg::QB-2:0], 1'b1};
    end else begin
      data_nxt.rem = trial[pfoa_pkg::DW-1:0];
      data_nxt.q   = {in_data.q[pfoa_pkg::QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/pfoa_checker.sv =====
// ----------------------------------------------------------------------------
// pfoa_checker
// Port-level checks for the pitch-from-offset unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pitch_from_offset_atan2_unit_defines.svh"

module pfoa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic [7:0] pending_r;
  logic [7:0] pending_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_nxt = pending_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `PFOA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  `PFOA_ASSERT_IMPL(a_pitch_range, out_tvalid,
    !out_tdata[15] && ($signed(out_tdata[14:0]) <= 15'sd9000) &&
    ($signed(out_tdata[14:0]) >= -15'sd9000), "pitch out of range")

  `PFOA_ASSERT_IMPL(a_no_phantom, out_tvalid, pending_r != 8'd0, "result without a pending item")

  `PFOA_ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid, "input stalled with no result waiting")

endmodule

bind pitch_from_offset_atan2_unit pfoa_checker u_pfoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pitch_from_offset_atan2_unit
// Streams signed lateral offsets through the unit under several arm heights
// and checks each pitch angle and last flag against a bit-exact CORDIC
// predictor, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int STEPS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = STEPS + 27 + 20;
  localparam int DIR_ROWS = 24;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 175;
  localparam longint RAD_TO_CD = 64'd375493621;
  localparam longint ATAN_STEP_CD [24] = '{
    294912000, 174096719, 91987925, 46694507,
    23437865, 11730358, 5866610, 2933484,
    1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716,
    358, 179, 90, 45
  };

  typedef struct {
    logic signed [14:0] pitch;
    logic               last;
  } pitch_res_t;

  typedef struct {
    logic [14:0]        height;
    logic signed [15:0] offset;
    logic               last;
    bit                 typed;
    logic signed [14:0] want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] lateral_offset
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [14:0] pitch_centideg, [15] zero
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = '0;

  pitch_res_t  pending_pitch [$];
  dir_row_t    dir_rows [DIR_ROWS];
  logic [14:0] arm_height;
  bit          idle_in;
  bit          idle_out;
  int          stall_left;
  int          errors;
  int          n_items;
  int          n_results;
  int          n_heights;
  int          cycle_count;

  pitch_from_offset_atan2_unit #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [14:0] pitch_from_offset(logic signed [15:0] offset,
                                                            logic [14:0] height);
    longint x, y, z, nx, ny, mag, r;
    int     steps;
    if (height == 0) begin
      if (offset > 0) return 15'sd9000;
      if (offset < 0) return -15'sd9000;
      return 15'sd0;
    end
    x = longint'(height) * 65536;
    y = longint'(offset) * 65536;
    z = 0;
    steps = (STEPS > 24) ? 24 : STEPS;
    for (int i = 0; i < steps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_STEP_CD[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_STEP_CD[i];
      end
      x = nx;
      y = ny;
    end
    z += (y * RAD_TO_CD) / x;
    mag = (z < 0) ? -z : z;
    r = (mag + 32768) >>> 16;
    if (r > 9000) r = 9000;
    return 15'((z < 0) ? -r : r);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("tb_top: mismatch in %s at result %0d: got %0d, want %0d",
             field, n_results, got, want);
    errors++;
  endtask

  // Sink side: random stall bursts while idle_out is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (idle_out && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    pitch_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pitch.size() == 0) begin
        $display("tb_top: result %0d arrived with nothing outstanding", n_results);
        errors++;
      end else begin
        want = pending_pitch.pop_front();
        if (out_tdata !== {1'b0, want.pitch})
          report_mismatch("pitch_centideg", int'($signed(out_tdata[14:0])), int'(want.pitch));
        if (out_tlast !== want.last)
          report_mismatch("result_is_last", int'(out_tlast), int'(want.last));
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timed out with %0d results outstanding", pending_pitch.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_offset(input logic signed [15:0] offset, input logic last,
                             input bit typed, input logic signed [14:0] want);
    pitch_res_t res;
    @(negedge clk);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = offset;
    in_tlast = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res.pitch = typed ? want : pitch_from_offset(offset, arm_height);
    res.last = last;
    pending_pitch.push_back(res);
    n_items++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_pitch.size() != 0) @(posedge clk);
  endtask

  task automatic set_height(input logic [14:0] height);
    drain_pipeline();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = height;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    arm_height = height;
    n_heights++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [14:0]        height;
    logic signed [15:0] offset;
    int                 h;

    dir_rows = '{
      '{15'd100, 16'sd0, 1'b0, 1'b0, 15'sd0},
      '{15'd100, 16'sd32767, 1'b1, 1'b0, 15'sd0},
      '{15'd100, -16'sd32768, 1'b0, 1'b0, 15'sd0},
      '{15'd100, 16'sd1, 1'b0, 1'b0, 15'sd0},
      '{15'd100, -16'sd1, 1'b1, 1'b0, 15'sd0},
      '{15'd100, 16'sd100, 1'b0, 1'b0, 15'sd0},
      '{15'd100, -16'sd100, 1'b0, 1'b0, 15'sd0},
      '{15'd100, 16'sh5555, 1'b1, 1'b0, 15'sd0},
      '{15'd100, 16'shAAAA, 1'b0, 1'b0, 15'sd0},
      '{15'd0, 16'sd0, 1'b0, 1'b1, 15'sd0},
      '{15'd0, 16'sd32767, 1'b1, 1'b1, 15'sd9000},
      '{15'd0, -16'sd32768, 1'b0, 1'b1, -15'sd9000},
      '{15'd0, 16'sd1, 1'b0, 1'b1, 15'sd9000},
      '{15'd0, -16'sd1, 1'b1, 1'b1, -15'sd9000},
      '{15'd32767, 16'sd0, 1'b0, 1'b0, 15'sd0},
      '{15'd32767, 16'sd32767, 1'b0, 1'b0, 15'sd0},
      '{15'd32767, -16'sd32768, 1'b1, 1'b0, 15'sd0},
      '{15'd32767, 16'sd1, 1'b0, 1'b0, 15'sd0},
      '{15'd32767, -16'sd1, 1'b0, 1'b0, 15'sd0},
      '{15'd1, 16'sd32767, 1'b1, 1'b0, 15'sd0},
      '{15'd1, -16'sd32768, 1'b0, 1'b0, 15'sd0},
      '{15'd1, 16'sd0, 1'b0, 1'b0, 15'sd0},
      '{15'd1, 16'sd1, 1'b0, 1'b0, 15'sd0},
      '{15'd1, -16'sd1, 1'b1, 1'b0, 15'sd0}
    };
    arm_height = 15'd100;
    idle_in = 1'b1;
    idle_out = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].height != arm_height) set_height(dir_rows[i].height);
      send_offset(dir_rows[i].offset, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: height = 15'd32767;
        1: height = 15'd0;
        2: height = 15'd1;
        3: height = 15'($urandom_range(2, 64));
        4: height = 15'd100;
        default: height = 15'($urandom_range(0, 32767));
      endcase
      if (p == RAND_PHASES - 1) begin
        idle_in = 1'b0;
        idle_out = 1'b0;
      end
      set_height(height);
      h = int'(height);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: offset = 16'($urandom);
          4, 5: offset = 16'(int'($urandom_range(0, 600)) - 300);
          6, 7: offset = 16'(int'($urandom_range(0, 2 * h)) - h);
          default: begin
            case ($urandom_range(0, 4))
              0: offset = 16'sd32767;
              1: offset = -16'sd32768;
              2: offset = 16'sd0;
              3: offset = 16'sd1;
              default: offset = -16'sd1;
            endcase
          end
        endcase
        send_offset(offset, 1'($urandom_range(0, 7) == 0), 1'b0, 15'sd0);
      end
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d offsets sent, %0d pitch results checked", n_items, n_results);
    $display("tb_top: %0d height writes, zero and full-scale heights included", n_heights);
    if (errors == 0 && pending_pitch.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pfoa_pkg.sv
hdl/pfoa_cordic_cell.sv
hdl/pfoa_div_cell.sv
hdl/pitch_from_offset_atan2_unit.sv
hdl/pfoa_checker.sv
sim/tb_top.sv
